@@ rtl/mqka_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Shared types, codes and helpers of the keepalive supervisor.
// No dependencies; every other file imports this package.

package mqka_pkg;

    localparam int COUNT_BITS   = 17;
    localparam int TICK_BITS    = 16;
    localparam int CFG_IDX_BITS = 4;

    typedef logic [COUNT_BITS-1:0]   count_t;
    typedef logic [TICK_BITS-1:0]    ticks_t;
    typedef logic [CFG_IDX_BITS-1:0] cfg_idx_t;

    typedef enum logic [2:0] {
        ACT_TICK      = 3'd0,
        ACT_CONNACK   = 3'd1,
        ACT_PINGRESP  = 3'd2,
        ACT_PACKET    = 3'd3,
        ACT_TRANSPORT = 3'd4,
        ACT_ACK_TMO   = 3'd5,
        ACT_CONNECT   = 3'd6
    } action_t;

    typedef enum logic [1:0] {
        DROP_NONE      = 2'd0,
        DROP_PING      = 2'd1,
        DROP_TRANSPORT = 2'd2,
        DROP_ACK_TMO   = 2'd3
    } drop_reason_t;

    typedef enum logic [1:0] {
        FLUSH_NONE  = 2'd0,
        FLUSH_ACKED = 2'd1,
        FLUSH_CLEAN = 2'd2
    } flush_kind_t;

    localparam cfg_idx_t REG_KEEPALIVE  = cfg_idx_t'(0);
    localparam cfg_idx_t REG_CLEAR_IDLE = cfg_idx_t'(1);

    localparam ticks_t KEEPALIVE_RESET  = ticks_t'(30);
    localparam ticks_t CLEAR_IDLE_RESET = ticks_t'(10);

    typedef struct packed {
        ticks_t keepalive_ticks;
        ticks_t clear_idle_ticks;
    } cfg_t;

    typedef struct packed {
        logic [2:0] action;
        logic [7:0] connack_code;
        logic       session_flag;
    } event_t;

    typedef struct packed {
        logic         send_ping;
        logic         link_dropped;
        drop_reason_t drop_reason;
        flush_kind_t  flush_kind;
        logic         session_present;
        logic         link_up;
    } result_t;

    function automatic count_t sat_inc(input count_t v);
        return (v == {COUNT_BITS{1'b1}}) ? v : v + count_t'(1);
    endfunction

endpackage

`default_nettype wire

@@ rtl/mqka_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Channel interfaces: event beats in, result beats out, register writes.
// Depends on mqka_pkg.

interface mqka_evt_if;
    import mqka_pkg::*;
    logic       valid;
    logic       ready;
    logic [2:0] action;
    logic [7:0] connack_code;
    logic       session_flag;
    modport source (output valid, action, connack_code, session_flag, input ready);
    modport sink   (input valid, action, connack_code, session_flag, output ready);
endinterface

interface mqka_res_if;
    import mqka_pkg::*;
    logic       valid;
    logic       ready;
    logic       send_ping;
    logic       link_dropped;
    logic [1:0] drop_reason;
    logic [1:0] flush_kind;
    logic       session_present;
    logic       link_up;
    modport source (output valid, send_ping, link_dropped, drop_reason, flush_kind,
                    session_present, link_up, input ready);
    modport sink   (input valid, send_ping, link_dropped, drop_reason, flush_kind,
                    session_present, link_up, output ready);
endinterface

interface mqka_cfg_if;
    import mqka_pkg::*;
    logic     valid;
    logic     ready;
    cfg_idx_t index;
    ticks_t   data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

@@ rtl/mqka_cfg_regs.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Configuration registers: keepalive and clear-idle tick limits.
// Depends on mqka_pkg and mqka_cfg_if.

module mqka_cfg_regs (
    input  wire logic    clk,
    input  wire logic    rst_n,
    mqka_cfg_if.sink     cfg,
    output mqka_pkg::cfg_t regs
);
    import mqka_pkg::*;

    ticks_t keepalive_reg;
    ticks_t clear_idle_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            keepalive_reg  <= KEEPALIVE_RESET;
            clear_idle_reg <= CLEAR_IDLE_RESET;
        end
        else if (cfg.valid)
        begin
            if (cfg.index == REG_KEEPALIVE)
                keepalive_reg <= cfg.data;
            if (cfg.index == REG_CLEAR_IDLE)
                clear_idle_reg <= cfg.data;
        end
    end

    assign regs.keepalive_ticks  = keepalive_reg;
    assign regs.clear_idle_ticks = clear_idle_reg;

endmodule

`default_nettype wire

@@ rtl/mqka_link_fsm.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Link state, idle counters and per-event decision logic.
// Depends on mqka_pkg.

module mqka_link_fsm (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       accept,
    input  wire mqka_pkg::event_t evt,
    input  wire mqka_pkg::cfg_t   regs,
    output mqka_pkg::result_t result
);
    import mqka_pkg::*;

    logic   connected_reg,    connected_next;
    logic   ping_pending_reg, ping_pending_next;
    count_t client_idle_reg,  client_idle_next;
    count_t server_idle_reg,  server_idle_next;
    count_t ping_wait_reg,    ping_wait_next;

    logic [TICK_BITS+1:0] ka_triple;
    count_t               ping_limit;
    ticks_t               server_limit;
    count_t               ci_inc, si_inc, pw_inc;

    always_comb
    begin
        ka_triple    = {2'b00, regs.keepalive_ticks} + {1'b0, regs.keepalive_ticks, 1'b0};
        ping_limit   = count_t'(ka_triple[TICK_BITS+1:1]);
        server_limit = (regs.keepalive_ticks > regs.clear_idle_ticks)
                       ? regs.keepalive_ticks : regs.clear_idle_ticks;
        ci_inc = sat_inc(client_idle_reg);
        si_inc = sat_inc(server_idle_reg);
        pw_inc = ping_pending_reg ? sat_inc(ping_wait_reg) : ping_wait_reg;
    end

    always_comb
    begin
        connected_next    = connected_reg;
        ping_pending_next = ping_pending_reg;
        client_idle_next  = client_idle_reg;
        server_idle_next  = server_idle_reg;
        ping_wait_next    = ping_wait_reg;
        result            = '0;

        case (action_t'(evt.action))
            ACT_TICK:
            begin
                if (connected_reg)
                begin
                    client_idle_next = ci_inc;
                    server_idle_next = si_inc;
                    ping_wait_next   = pw_inc;
                    if (pw_inc > ping_limit)
                    begin
                        result.link_dropped = 1'b1;
                        result.drop_reason  = DROP_PING;
                        connected_next      = 1'b0;
                        ping_pending_next   = 1'b0;
                        client_idle_next    = '0;
                        server_idle_next    = '0;
                        ping_wait_next      = '0;
                    end
                    else if (ci_inc > count_t'(regs.keepalive_ticks))
                    begin
                        result.send_ping  = 1'b1;
                        ping_pending_next = 1'b1;
                        client_idle_next  = '0;
                    end
                    else if (si_inc > count_t'(server_limit))
                    begin
                        result.send_ping  = 1'b1;
                        ping_pending_next = 1'b1;
                        server_idle_next  = '0;
                    end
                    else if (si_inc == count_t'(regs.clear_idle_ticks))
                    begin
                        result.flush_kind = FLUSH_ACKED;
                    end
                end
            end
            ACT_CONNACK:
            begin
                server_idle_next = '0;
                if (evt.connack_code != 8'd0)
                begin
                    if (connected_reg)
                    begin
                        result.link_dropped = 1'b1;
                        connected_next      = 1'b0;
                        ping_pending_next   = 1'b0;
                        client_idle_next    = '0;
                        ping_wait_next      = '0;
                    end
                end
                else
                begin
                    connected_next         = 1'b1;
                    client_idle_next       = '0;
                    ping_wait_next         = '0;
                    result.session_present = evt.session_flag;
                    result.flush_kind      = evt.session_flag ? FLUSH_ACKED : FLUSH_CLEAN;
                end
            end
            ACT_PINGRESP:
            begin
                server_idle_next  = '0;
                ping_wait_next    = '0;
                ping_pending_next = 1'b0;
            end
            ACT_PACKET:
            begin
                server_idle_next = '0;
            end
            ACT_TRANSPORT, ACT_ACK_TMO:
            begin
                if (connected_reg)
                begin
                    result.link_dropped = 1'b1;
                    result.drop_reason  = (action_t'(evt.action) == ACT_TRANSPORT)
                                          ? DROP_TRANSPORT : DROP_ACK_TMO;
                    connected_next      = 1'b0;
                    ping_pending_next   = 1'b0;
                    client_idle_next    = '0;
                    server_idle_next    = '0;
                    ping_wait_next      = '0;
                end
            end
            ACT_CONNECT:
            begin
                if (!connected_reg)
                begin
                    client_idle_next = '0;
                    server_idle_next = '0;
                    ping_wait_next   = '0;
                end
            end
            default:
            begin
            end
        endcase

        result.link_up = connected_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            connected_reg    <= 1'b0;
            ping_pending_reg <= 1'b0;
            client_idle_reg  <= '0;
            server_idle_reg  <= '0;
            ping_wait_reg    <= '0;
        end
        else if (accept)
        begin
            connected_reg    <= connected_next;
            ping_pending_reg <= ping_pending_next;
            client_idle_reg  <= client_idle_next;
            server_idle_reg  <= server_idle_next;
            ping_wait_reg    <= ping_wait_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/mqka_out_stage.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Result register: holds one result beat until the receiver takes it.
// Depends on mqka_pkg and mqka_res_if.

module mqka_out_stage (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          load,
    input  wire mqka_pkg::result_t result,
    output logic               space,
    mqka_res_if.source         res
);
    import mqka_pkg::*;

    logic    valid_reg;
    result_t result_reg;

    assign space = !valid_reg || res.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (space)
            valid_reg <= load;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            result_reg <= result;
    end

    assign res.valid           = valid_reg;
    assign res.send_ping       = result_reg.send_ping;
    assign res.link_dropped    = result_reg.link_dropped;
    assign res.drop_reason     = result_reg.drop_reason;
    assign res.flush_kind      = result_reg.flush_kind;
    assign res.session_present = result_reg.session_present;
    assign res.link_up         = result_reg.link_up;

endmodule

`default_nettype wire

@@ rtl/mqtt_keepalive_supervisor_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// MQTT link keepalive supervisor, top level.
// Depends on mqka_pkg, the mqka interfaces, mqka_cfg_regs, mqka_link_fsm, mqka_out_stage.
//
// Channels: evt carries one link event per beat (tick, CONNACK, PINGRESP,
// other packet, transport lost, ack timeout, connect request); res returns
// exactly one result beat per event; cfg writes the keepalive (index 0) and
// clear-idle (index 1) tick limits, always ready; the user must write them only
// while no event is in flight, as the block itself does not enforce this.
// Result: registered, so its beat appears in the cycle after the event beat is accepted.
// Throughput: one event per cycle unless stalled; the decision is a single pass of compares
// on the state registers, and the result register frees itself in the cycle
// the receiver takes its beat.
// Stall: while a result waits unread, evt.ready falls, link state holds.
// Reset: link down, ping flag clear, counters zero, limits 30 and 10 ticks,
// result channel empty.

module mqtt_keepalive_supervisor_core (
    input  wire logic clk,
    input  wire logic rst_n,
    mqka_evt_if.sink  evt,
    mqka_res_if.source res,
    mqka_cfg_if.sink  cfg
);
    import mqka_pkg::*;

    cfg_t    regs;
    event_t  evt_beat;
    result_t result;
    logic    space;
    logic    accept;

    assign evt.ready = space;
    assign accept    = evt.valid && space;

    assign evt_beat.action       = evt.action;
    assign evt_beat.connack_code = evt.connack_code;
    assign evt_beat.session_flag = evt.session_flag;

    mqka_cfg_regs u_cfg_regs (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .regs  (regs)
    );

    mqka_link_fsm u_link_fsm (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .evt    (evt_beat),
        .regs   (regs),
        .result (result)
    );

    mqka_out_stage u_out_stage (
        .clk    (clk),
        .rst_n  (rst_n),
        .load   (accept),
        .result (result),
        .space  (space),
        .res    (res)
    );

    a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> res.valid)
        else $error("accepted event produced no result beat");

    a_drop_leaves_down: assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && res.link_dropped) |-> !res.link_up)
        else $error("link reported dropped but still up");

    a_ping_only_up: assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && res.send_ping) |-> (res.link_up && !res.link_dropped))
        else $error("ping requested on a link that is down");

    a_clean_no_session: assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && res.flush_kind == FLUSH_CLEAN) |-> !res.session_present)
        else $error("clean start flagged with session present");

endmodule

`default_nettype wire
